### src/pctc_pkg.sv
// Shared types, constants and codes for the phonetic context tree classifier.
`timescale 1ns / 1ps
package pctc_pkg;

    // Table sizes
    localparam int NODE_COUNT    = 1024;
    localparam int CLASS_COUNT   = 256;
    localparam int PHONE_COUNT   = 64;
    localparam int CONTEXT_ORDER = 2;

    // Derived widths
    localparam int NODE_AW  = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
    localparam int CLASS_AW = (CLASS_COUNT > 1) ? $clog2(CLASS_COUNT) : 1;
    localparam int STEP_W   = NODE_AW;
    localparam int CHILD_W  = 10;
    localparam int NODE_W   = 47;
    localparam int MASK_W   = 64;
    localparam int PHONE_W  = 6;

    // Command codes
    typedef enum logic [1:0] {
        CMD_NODE_WR  = 2'd0,
        CMD_CLASS_WR = 2'd1,
        CMD_CLASSIFY = 2'd2
    } cmd_t;

    // Node question codes
    typedef enum logic [2:0] {
        KIND_LEAF     = 3'd0,
        KIND_LEFT0    = 3'd1,
        KIND_LEFT1    = 3'd2,
        KIND_CENTRE   = 3'd3,
        KIND_RIGHT0   = 3'd4,
        KIND_RIGHT1   = 3'd5,
        KIND_POSITION = 3'd6,
        KIND_STATE    = 3'd7
    } node_kind_t;

    // Walk sequencer states
    typedef enum logic [2:0] {
        WS_IDLE,
        WS_NODE_RD,
        WS_NODE_EVAL,
        WS_CLASS_EVAL,
        WS_DONE
    } walk_state_t;

    // Input beat
    typedef struct packed {
        logic [1:0]          cmd;
        logic [9:0]          slot;
        logic [2:0]          node_kind;
        logic [CHILD_W-1:0]  yes_child;
        logic [CHILD_W-1:0]  no_child;
        logic [7:0]          test_value;
        logic [15:0]         leaf_state;
        logic [MASK_W-1:0]   class_bits;
        logic [23:0]         context_phones;
        logic [PHONE_W-1:0]  center_phone;
        logic [7:0]          word_position;
        logic [7:0]          query_state;
    } in_t;

    // Result beat
    typedef struct packed {
        logic [15:0] hmm_index;
        logic        walk_error;
    } out_t;

    // Node table entry (47 bits)
    typedef struct packed {
        logic [2:0]         kind;
        logic [CHILD_W-1:0] yes_child;
        logic [CHILD_W-1:0] no_child;
        logic [7:0]         value;
        logic [15:0]        leaf;
    } node_t;

    // Context held for one walk
    typedef struct packed {
        logic [23:0]        context_phones;
        logic [PHONE_W-1:0] center_phone;
        logic [7:0]         word_position;
        logic [7:0]         query_state;
    } ctx_t;

    // Outcome of the node question unit
    typedef struct packed {
        logic               is_leaf;
        logic               needs_class;
        logic               direct_ans;
        logic               class_ok;
        logic [PHONE_W-1:0] phone;
    } test_t;

    // Table read requests from the walker
    typedef struct packed {
        logic                node_re;
        logic [NODE_AW-1:0]  node_raddr;
        logic                class_re;
        logic [CLASS_AW-1:0] class_raddr;
    } mem_rd_t;

endpackage

### src/pctc_ram.sv
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps
module pctc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // Registered read port, holds between reads
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### src/pctc_node_test.sv
// Node question unit: picks the phone under test and answers direct compares.
`timescale 1ns / 1ps
module pctc_node_test (
    input  pctc_pkg::node_t node,
    input  pctc_pkg::ctx_t  ctx,
    output pctc_pkg::test_t test
);
    import pctc_pkg::*;

    logic               pos_ok;
    logic [PHONE_W-1:0] phone;

    // Question decode
    always_comb
    begin
        test.is_leaf     = 1'b0;
        test.needs_class = 1'b0;
        test.direct_ans  = 1'b0;
        pos_ok           = 1'b1;
        phone            = ctx.center_phone;
        case (node.kind)
            KIND_LEAF:
            begin
                test.is_leaf = 1'b1;
            end
            KIND_LEFT0:
            begin
                test.needs_class = 1'b1;
                phone            = ctx.context_phones[5:0];
            end
            KIND_LEFT1:
            begin
                test.needs_class = 1'b1;
                phone            = ctx.context_phones[11:6];
                pos_ok           = (CONTEXT_ORDER > 1);
            end
            KIND_CENTRE:
            begin
                test.needs_class = 1'b1;
                phone            = ctx.center_phone;
            end
            KIND_RIGHT0:
            begin
                test.needs_class = 1'b1;
                phone            = ctx.context_phones[17:12];
            end
            KIND_RIGHT1:
            begin
                test.needs_class = 1'b1;
                phone            = ctx.context_phones[23:18];
                pos_ok           = (CONTEXT_ORDER > 1);
            end
            KIND_POSITION:
            begin
                test.direct_ans = (node.value == ctx.word_position);
            end
            KIND_STATE:
            begin
                test.direct_ans = (node.value == ctx.query_state);
            end
            default:
            begin
                test.is_leaf = 1'b1;
            end
        endcase
        // Out-of-range class, phone or context position answers no
        test.phone    = phone;
        test.class_ok = pos_ok
                        && (32'(node.value) < CLASS_COUNT)
                        && (32'(phone) < PHONE_COUNT);
    end

endmodule

### src/pctc_walker.sv
// Tree walk sequencer: one node read and question per step, class read when needed.
`timescale 1ns / 1ps
module pctc_walker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  pctc_pkg::ctx_t                ctx_in,
    output logic                          busy,
    output pctc_pkg::mem_rd_t             rd,
    input  logic [pctc_pkg::NODE_W-1:0]   node_rdata,
    input  logic [pctc_pkg::MASK_W-1:0]   class_rdata,
    output logic                          res_valid,
    input  logic                          res_ready,
    output pctc_pkg::out_t                res
);
    import pctc_pkg::*;

    walk_state_t        state_reg, state_next;
    logic [CHILD_W-1:0] idx_reg, idx_next;
    logic [STEP_W-1:0]  step_reg, step_next;
    ctx_t               ctx_reg, ctx_next;
    logic [PHONE_W-1:0] phone_reg, phone_next;
    logic               class_ok_reg, class_ok_next;
    out_t               res_reg, res_next;

    node_t              node;
    test_t              test;
    logic               ans;
    logic [CHILD_W-1:0] child;
    logic               walk_end;

    assign node = node_t'(node_rdata);

    pctc_node_test u_test (
        .node (node),
        .ctx  (ctx_reg),
        .test (test)
    );

    // Answer and successor of the current node
    assign ans      = (state_reg == WS_CLASS_EVAL) ? (class_ok_reg && class_rdata[phone_reg])
                                                   : test.direct_ans;
    assign child    = ans ? node.yes_child : node.no_child;
    assign walk_end = (step_reg == STEP_W'(NODE_COUNT - 1)) || (32'(child) >= NODE_COUNT);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            WS_IDLE:
            begin
                if (start)
                begin
                    state_next = WS_NODE_RD;
                end
            end
            WS_NODE_RD:
            begin
                state_next = WS_NODE_EVAL;
            end
            WS_NODE_EVAL:
            begin
                if (test.is_leaf)
                begin
                    state_next = WS_DONE;
                end
                else if (test.needs_class)
                begin
                    state_next = WS_CLASS_EVAL;
                end
                else if (walk_end)
                begin
                    state_next = WS_DONE;
                end
                else
                begin
                    state_next = WS_NODE_RD;
                end
            end
            WS_CLASS_EVAL:
            begin
                state_next = walk_end ? WS_DONE : WS_NODE_RD;
            end
            WS_DONE:
            begin
                if (res_ready)
                begin
                    state_next = WS_IDLE;
                end
            end
            default:
            begin
                state_next = WS_IDLE;
            end
        endcase
    end

    // State outputs
    always_comb
    begin
        rd.node_re     = (state_reg == WS_NODE_RD);
        rd.node_raddr  = NODE_AW'(idx_reg);
        rd.class_re    = (state_reg == WS_NODE_EVAL);
        rd.class_raddr = CLASS_AW'(node.value);
        res_valid      = (state_reg == WS_DONE);
        busy           = (state_reg != WS_IDLE);
    end

    // Walk datapath
    always_comb
    begin
        idx_next      = idx_reg;
        step_next     = step_reg;
        ctx_next      = ctx_reg;
        phone_next    = phone_reg;
        class_ok_next = class_ok_reg;
        res_next      = res_reg;
        if (state_reg == WS_IDLE && start)
        begin
            idx_next  = '0;
            step_next = '0;
            ctx_next  = ctx_in;
        end
        else if (state_reg == WS_NODE_EVAL)
        begin
            phone_next    = test.phone;
            class_ok_next = test.class_ok;
            if (test.is_leaf)
            begin
                res_next.hmm_index  = node.leaf;
                res_next.walk_error = 1'b0;
            end
            else if (!test.needs_class)
            begin
                if (walk_end)
                begin
                    res_next.hmm_index  = '0;
                    res_next.walk_error = 1'b1;
                end
                else
                begin
                    idx_next  = child;
                    step_next = step_reg + STEP_W'(1);
                end
            end
        end
        else if (state_reg == WS_CLASS_EVAL)
        begin
            if (walk_end)
            begin
                res_next.hmm_index  = '0;
                res_next.walk_error = 1'b1;
            end
            else
            begin
                idx_next  = child;
                step_next = step_reg + STEP_W'(1);
            end
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= WS_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Walk payload
    always_ff @(posedge clk)
    begin
        idx_reg      <= idx_next;
        step_reg     <= step_next;
        ctx_reg      <= ctx_next;
        phone_reg    <= phone_next;
        class_ok_reg <= class_ok_next;
        res_reg      <= res_next;
    end

    assign res = res_reg;

endmodule

### src/phonetic_context_tree_classifier_core.sv
// Top level of the phonetic decision-tree classifier: tables, walker, result register.
//
// Usage:
//   item channel (item_valid/item_ready/item) carries one command per beat:
//   a node write, a class mask write, or a classify request. Writes to slots
//   beyond the table size, and unused commands, are dropped with no result.
//   Writes yield no result beat.
//   A classify walks the tree from node 0 and yields one result beat on the
//   result channel (result_valid/result_ready/result): the tied-state index
//   of the leaf reached, or walk_error with index 0 on a bad table.
//   Each visited node, leaf included, passes a node read state and a question
//   state, plus a class-mask read state for phone-class questions; the done
//   state then moves the result into the output register, and item_ready
//   rises with result_valid. The node table has a single registered read port.
//   Reset clears control only; table contents are undefined until written.
//   A stalled receiver holds the result beat in the output register while new
//   writes are still taken; a second classify finishes and then waits in the
//   walker until the output register frees.
`timescale 1ns / 1ps
module phonetic_context_tree_classifier_core (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           item_valid,
    output logic           item_ready,
    input  pctc_pkg::in_t  item,
    output logic           result_valid,
    input  logic           result_ready,
    output pctc_pkg::out_t result
);
    import pctc_pkg::*;

    logic    accept;
    logic    start;
    logic    busy;
    logic    node_we;
    logic    class_we;
    node_t   node_wdata;
    mem_rd_t rd;
    logic [NODE_W-1:0] node_rdata;
    logic [MASK_W-1:0] class_rdata;
    ctx_t    ctx_in;
    logic    res_valid;
    logic    res_ready;
    out_t    res;

    logic    result_valid_reg, result_valid_next;
    out_t    result_reg, result_next;

    // Command decode
    assign item_ready = !busy;
    assign accept     = item_valid && item_ready;
    assign start      = accept && (item.cmd == CMD_CLASSIFY);
    assign node_we    = accept && (item.cmd == CMD_NODE_WR) && (32'(item.slot) < NODE_COUNT);
    assign class_we   = accept && (item.cmd == CMD_CLASS_WR) && (32'(item.slot) < CLASS_COUNT);

    assign node_wdata.kind      = item.node_kind;
    assign node_wdata.yes_child = item.yes_child;
    assign node_wdata.no_child  = item.no_child;
    assign node_wdata.value     = item.test_value;
    assign node_wdata.leaf      = item.leaf_state;

    assign ctx_in.context_phones = item.context_phones;
    assign ctx_in.center_phone   = item.center_phone;
    assign ctx_in.word_position  = item.word_position;
    assign ctx_in.query_state    = item.query_state;

    // Node table
    pctc_ram #(
        .WIDTH (NODE_W),
        .DEPTH (NODE_COUNT)
    ) u_node_ram (
        .clk   (clk),
        .we    (node_we),
        .waddr (NODE_AW'(item.slot)),
        .wdata (NODE_W'(node_wdata)),
        .re    (rd.node_re),
        .raddr (rd.node_raddr),
        .rdata (node_rdata)
    );

    // Class mask table
    pctc_ram #(
        .WIDTH (MASK_W),
        .DEPTH (CLASS_COUNT)
    ) u_class_ram (
        .clk   (clk),
        .we    (class_we),
        .waddr (CLASS_AW'(item.slot)),
        .wdata (item.class_bits),
        .re    (rd.class_re),
        .raddr (rd.class_raddr),
        .rdata (class_rdata)
    );

    // Walk sequencer
    pctc_walker u_walker (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .ctx_in      (ctx_in),
        .busy        (busy),
        .rd          (rd),
        .node_rdata  (node_rdata),
        .class_rdata (class_rdata),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res         (res)
    );

    // Output register
    assign res_ready = !result_valid_reg || result_ready;

    always_comb
    begin
        result_valid_next = result_valid_reg;
        result_next       = result_reg;
        if (res_valid && res_ready)
        begin
            result_valid_next = 1'b1;
            result_next       = res;
        end
        else if (result_ready)
        begin
            result_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule
